/* rtl/core/barge_in_speech_detector_macros.svh */
// Assertion macros shared by the barge-in speech detector RTL.
`ifndef BARGE_IN_SPEECH_DETECTOR_MACROS_SVH
`define BARGE_IN_SPEECH_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define BISD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define BISD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BISD_ASSERT(label, clk, rst_n, prop, msg)
`define BISD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/bisd_pkg.sv */
// Types and constants of the barge-in speech detector.
package bisd_pkg;

    // Event codes
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_REARM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEECH_CONFIRM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TS_TOLERANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_SILENCE_REARM = 16'd180;
    localparam logic [15:0] RST_SPEECH_CONFIRM = 16'd180;
    localparam logic [9:0]  RST_TS_TOLERANCE = 10'd30;
    localparam logic [31:0] RST_MIN_POWER = 32'd65536;
    localparam logic [9:0]  RST_MAX_FRAME = 10'd120;

    // Speech accumulator saturates at its full 17-bit range
    localparam logic [16:0] SPEECH_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] time_ms;
        logic [9:0]  frame_ms;
        logic        vad_ok;
        logic        vad_voice;
        logic [31:0] frame_power;
    } t_in_beat;

    typedef struct packed {
        logic        fired;
        logic [31:0] onset_time_ms;
    } t_out_beat;

endpackage

/* rtl/core/barge_in_speech_detector.sv */
// Barge-in speech detector: flags a user talking over playback.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) carries start, stop
// and VAD frame events; every accepted beat yields exactly one result beat on
// the output channel (o_out_valid / i_out_ready, payload o_out).
// An accepted beat waits in the input register; the detector state and the
// result register then update together, when the result register is free.
// The detector takes one beat per cycle while the receiver does not stall;
// the tracking state update (subtract, compare, saturating add) is one step.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; o_in_ready falls only when both are full.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at the
// next edge; indexes past the register list are dropped.
// Synchronous reset restores register defaults, clears playback and
// evidence state and empties both pipeline registers.
`include "barge_in_speech_detector_macros.svh"

module barge_in_speech_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  bisd_pkg::t_in_beat               i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output bisd_pkg::t_out_beat              o_out,
    input  logic                             i_cfg_we,
    input  logic [bisd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bisd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bisd_pkg::*;

    // Configuration registers
    logic [15:0] r_silence_rearm;
    logic [15:0] r_speech_confirm;
    logic [9:0]  r_ts_tolerance;
    logic [31:0] r_min_power;
    logic [9:0]  r_max_frame;

    // Pipeline registers
    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;

    // Detector state
    logic        r_playing, n_playing;
    logic        r_has_fired, n_has_fired;
    logic        r_armed, n_armed;
    logic        r_have_prev, n_have_prev;
    logic [15:0] r_silence_acc, n_silence_acc;
    logic [16:0] r_speech_acc, n_speech_acc;
    logic [31:0] r_prev_end, n_prev_end;
    logic [31:0] r_start_time, n_start_time;
    logic [31:0] r_onset_time, n_onset_time;
    t_out_beat   n_out;

    logic w_out_free;
    logic w_step;

    // Frame evaluation terms
    logic [31:0] w_since_start;
    logic        w_too_early;
    logic        w_reject;
    logic [31:0] w_delta;
    logic [32:0] w_delta_tol;
    logic [10:0] w_dur_tol;
    logic        w_bad_spacing;
    logic        w_quiet;
    logic        w_armed_e;
    logic [15:0] w_silence_e;
    logic [16:0] w_speech_e;
    logic [16:0] w_sil_sum;
    logic [15:0] w_sil_sat;
    logic [17:0] w_sp_sum;
    logic [16:0] w_sp_sat;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence_rearm  <= RST_SILENCE_REARM;
            r_speech_confirm <= RST_SPEECH_CONFIRM;
            r_ts_tolerance   <= RST_TS_TOLERANCE;
            r_min_power      <= RST_MIN_POWER;
            r_max_frame      <= RST_MAX_FRAME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SILENCE_REARM:  r_silence_rearm  <= i_cfg_data[15:0];
                CFG_SPEECH_CONFIRM: r_speech_confirm <= i_cfg_data[15:0];
                CFG_TS_TOLERANCE:   r_ts_tolerance   <= i_cfg_data[9:0];
                CFG_MIN_POWER:      r_min_power      <= i_cfg_data;
                CFG_MAX_FRAME:      r_max_frame      <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Frame checks against start time and previous frame end
    always_comb begin
        w_since_start = r_in.time_ms - r_start_time;
        w_too_early   = $signed(w_since_start) < $signed({22'd0, r_in.frame_ms});
        w_reject      = !r_in.vad_ok || (r_in.frame_ms == 10'd0) ||
                        (r_in.frame_ms > r_max_frame) || w_too_early;

        // Spacing: only meaningful when delta is positive, which the first two terms cover
        w_delta       = r_in.time_ms - r_prev_end;
        w_delta_tol   = {1'b0, w_delta} + {23'd0, r_ts_tolerance};
        w_dur_tol     = {1'b0, r_in.frame_ms} + {1'b0, r_ts_tolerance};
        w_bad_spacing = w_delta[31] || (w_delta == 32'd0) ||
                        (w_delta_tol < {23'd0, r_in.frame_ms}) ||
                        (w_delta > {21'd0, w_dur_tol});

        // Evidence after a possible spacing reset
        w_armed_e   = r_armed;
        w_silence_e = r_silence_acc;
        w_speech_e  = r_speech_acc;
        if (r_have_prev && w_bad_spacing) begin
            w_armed_e   = 1'b0;
            w_silence_e = 16'd0;
            w_speech_e  = 17'd0;
        end

        w_quiet = !r_in.vad_voice || (r_in.frame_power < r_min_power);

        // Saturating accumulators
        w_sil_sum = {1'b0, w_silence_e} + {7'd0, r_in.frame_ms};
        w_sil_sat = (w_sil_sum > {1'b0, r_silence_rearm}) ? r_silence_rearm
                                                          : w_sil_sum[15:0];
        w_sp_sum  = {1'b0, w_speech_e} + {8'd0, r_in.frame_ms};
        w_sp_sat  = w_sp_sum[17] ? SPEECH_MAX : w_sp_sum[16:0];
    end

    // Next state and result for the item in the input register
    always_comb begin
        n_playing     = r_playing;
        n_has_fired   = r_has_fired;
        n_armed       = r_armed;
        n_have_prev   = r_have_prev;
        n_silence_acc = r_silence_acc;
        n_speech_acc  = r_speech_acc;
        n_prev_end    = r_prev_end;
        n_start_time  = r_start_time;
        n_onset_time  = r_onset_time;
        n_out         = '0;

        unique case (r_in.op) inside
            OP_START, OP_STOP: begin
                n_playing     = (r_in.op == OP_START);
                n_has_fired   = 1'b0;
                n_armed       = 1'b0;
                n_have_prev   = 1'b0;
                n_silence_acc = 16'd0;
                n_speech_acc  = 17'd0;
                n_prev_end    = 32'd0;
                n_start_time  = (r_in.op == OP_START) ? r_in.time_ms : 32'd0;
                n_onset_time  = 32'd0;
            end
            OP_FRAME: begin
                if (r_playing && !r_has_fired) begin
                    if (w_reject) begin
                        n_armed       = 1'b0;
                        n_have_prev   = 1'b0;
                        n_silence_acc = 16'd0;
                        n_speech_acc  = 17'd0;
                    end else begin
                        n_have_prev = 1'b1;
                        n_prev_end  = r_in.time_ms;
                        if (w_quiet) begin
                            n_speech_acc  = 17'd0;
                            n_silence_acc = w_sil_sat;
                            n_armed       = (w_sil_sat >= r_silence_rearm);
                        end else begin
                            n_silence_acc = 16'd0;
                            n_armed       = w_armed_e;
                            n_speech_acc  = w_speech_e;
                            if (w_armed_e) begin
                                // Onset is latched on the first speech frame of a run
                                if (w_speech_e == 17'd0) begin
                                    n_onset_time = r_in.time_ms - {22'd0, r_in.frame_ms};
                                end
                                n_speech_acc = w_sp_sat;
                                if (w_sp_sat >= {1'b0, r_speech_confirm}) begin
                                    n_has_fired         = 1'b1;
                                    n_out.fired         = 1'b1;
                                    n_out.onset_time_ms = n_onset_time;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_playing     <= 1'b0;
            r_has_fired   <= 1'b0;
            r_armed       <= 1'b0;
            r_have_prev   <= 1'b0;
            r_silence_acc <= 16'd0;
            r_speech_acc  <= 17'd0;
            r_prev_end    <= 32'd0;
            r_start_time  <= 32'd0;
            r_onset_time  <= 32'd0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_playing     <= n_playing;
                r_has_fired   <= n_has_fired;
                r_armed       <= n_armed;
                r_have_prev   <= n_have_prev;
                r_silence_acc <= n_silence_acc;
                r_speech_acc  <= n_speech_acc;
                r_prev_end    <= n_prev_end;
                r_start_time  <= n_start_time;
                r_onset_time  <= n_onset_time;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_step) begin
            r_out <= n_out;
        end
    end

    // Checks
    `BISD_ASSERT(a_fired_needs_playing, i_clk, i_rst_n,
                 r_has_fired |-> r_playing, "fired while not playing")
    `BISD_ASSERT(a_speech_needs_armed, i_clk, i_rst_n,
                 (r_speech_acc != 17'd0) |-> r_armed, "speech accumulated while not armed")
    `BISD_ASSERT_NEXT(a_fire_has_result, i_clk, i_rst_n,
                      w_step && !r_has_fired && n_has_fired,
                      r_out_valid && r_out.fired, "fire without fired result")
    `BISD_ASSERT(a_quiet_result_zero, i_clk, i_rst_n,
                 (r_out_valid && !r_out.fired) |-> (r_out.onset_time_ms == 32'd0),
                 "onset set on non-fired result")

endmodule
